// ----- sv/chit_pkg.sv -----
package chit_pkg;
  localparam int unsigned HashBucketsDef = 256;
  localparam int unsigned NodePoolDef    = 1024;
  localparam int unsigned EntrySlotsDef  = 4096;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned SlotW   = 12;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_WAIT,
    S_NODE_RD,
    S_NODE_WAIT,
    S_FREE_WAIT,
    S_UNLINK,
    S_OUT
  } fsm_t;
endpackage

// ----- sv/chit_if.sv -----
interface chit_in_if;
  import chit_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [KeyW-1:0]   block_id;
  logic [SlotW-1:0]  entry_index;
  modport source (output valid, cmd, block_id, entry_index, input ready);
  modport sink   (input valid, cmd, block_id, entry_index, output ready);
endinterface

interface chit_out_if;
  import chit_pkg::*;
  logic                valid;
  logic                ready;
  logic [StatusW-1:0]  status;
  logic                hit;
  logic [SlotW-1:0]    found_index;
  modport source (output valid, status, hit, found_index, input ready);
  modport sink   (input valid, status, hit, found_index, output ready);
endinterface

// ----- sv/chit_head_mem.sv -----
module chit_head_mem
  import chit_pkg::*;
#(
  parameter int unsigned DEPTH = HashBucketsDef,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
  assign rdata = rdata_r;
endmodule

// ----- sv/chit_node_mem.sv -----
module chit_node_mem
  import chit_pkg::*;
#(
  parameter int unsigned DEPTH = NodePoolDef,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 55
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end
  assign rdata = rdata_r;
endmodule

// ----- sv/chained_hash_index_table.sv -----
// Each operation steps through its states: an insert reads the chain head and
//   the free-list head (S_HEAD_RD), pushes the new node (S_FREE_WAIT) and replies;
//   a pool-full reply or unknown command replies from S_HEAD_RD; lookup and delete
//   read the head, then walk the chain node by node. Throughput: one operation at
//   a time; the next input is taken only after the result transfer.
// Reset: synchronous active low; afterwards a clearing pass writes every
//   bucket head empty, one per cycle, before in_ready.
module chained_hash_index_table
  import chit_pkg::*;
#(
  parameter int unsigned HASH_BUCKETS = HashBucketsDef,
  parameter int unsigned NODE_POOL    = NodePoolDef,
  parameter int unsigned ENTRY_SLOTS  = EntrySlotsDef
) (
  input logic clk,
  input logic rst_n,
  chit_in_if.sink    in_ch,
  chit_out_if.source out_ch
);
  // Links are node number plus one; zero means no node.
  localparam int unsigned BW = (HASH_BUCKETS > 1) ? $clog2(HASH_BUCKETS) : 1;
  localparam int unsigned NW = (NODE_POOL > 1) ? $clog2(NODE_POOL) : 1;
  localparam int unsigned LW = $clog2(NODE_POOL + 1);
  localparam int unsigned EW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int unsigned ND = KeyW + EW + LW;
  localparam logic [LW-1:0] POOL_L = LW'(NODE_POOL);

  fsm_t state_r, state_nxt;

  // Held operation.
  logic [CmdW-1:0] cmd_r;
  logic [KeyW-1:0] key_r;
  logic [EW-1:0]   slot_r;
  logic [BW-1:0]   bkt_r, clr_r, clr_nxt;

  logic [LW-1:0] cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0] alloc_r, alloc_nxt, free_r, free_nxt;
  logic [LW-1:0] steps_r, steps_nxt;

  // Key and slot of the predecessor node, kept for its rewrite on unlink.
  logic [KeyW-1:0] pkey_r, pkey_nxt;
  logic [EW-1:0]   pslot_r, pslot_nxt;

  logic [StatusW-1:0] st_r, st_nxt;
  logic               hit_r, hit_nxt;
  logic [SlotW-1:0]   fidx_r, fidx_nxt;

  // Memory ports.
  logic          h_we;
  logic [BW-1:0] h_waddr, h_raddr;
  logic [LW-1:0] h_wdata, h_rdata;
  logic          n_we;
  logic [NW-1:0] n_waddr, n_raddr;
  logic [ND-1:0] n_wdata, n_rdata;

  logic [KeyW-1:0] rd_key;
  logic [EW-1:0]   rd_slot;
  logic [LW-1:0]   rd_next;
  logic [BW-1:0]   in_bkt;

  assign rd_key  = n_rdata[ND-1 -: KeyW];
  assign rd_slot = n_rdata[LW +: EW];
  assign rd_next = n_rdata[LW-1:0];

  // Bucket = key modulo bucket count.
  if (HASH_BUCKETS > 1) begin : g_bkt
    assign in_bkt = BW'(in_ch.block_id % KeyW'(HASH_BUCKETS));
  end else begin : g_bkt1
    assign in_bkt = '0;
  end

  chit_head_mem #(.DEPTH(HASH_BUCKETS), .AW(BW), .DW(LW)) u_head (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  chit_node_mem #(.DEPTH(NODE_POOL), .AW(NW), .DW(ND)) u_node (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  function automatic logic link_ok(input logic [LW-1:0] l, input logic [LW-1:0] pool);
    link_ok = (l != '0) && (l <= pool);
  endfunction

  function automatic logic [NW-1:0] to_addr(input logic [LW-1:0] l);
    logic [LW-1:0] t;
    t = l - LW'(1);
    to_addr = t[NW-1:0];
  endfunction

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.status    = st_r;
  assign out_ch.hit       = hit_r;
  assign out_ch.found_index = fidx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      alloc_r <= '0;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      alloc_r <= alloc_nxt;
      free_r  <= free_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd_r  <= in_ch.cmd;
      key_r  <= in_ch.block_id;
      slot_r <= EW'(32'(in_ch.entry_index) % ENTRY_SLOTS);
      bkt_r  <= in_bkt;
    end
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    steps_r <= steps_nxt;
    pkey_r  <= pkey_nxt;
    pslot_r <= pslot_nxt;
    st_r    <= st_nxt;
    hit_r   <= hit_nxt;
    fidx_r  <= fidx_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    alloc_nxt = alloc_r;
    free_nxt  = free_r;
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    steps_nxt = steps_r;
    pkey_nxt  = pkey_r;
    pslot_nxt = pslot_r;
    st_nxt    = st_r;
    hit_nxt   = hit_r;
    fidx_nxt  = fidx_r;
    h_we    = 1'b0;
    h_waddr = bkt_r;
    h_wdata = '0;
    h_raddr = bkt_r;
    n_we    = 1'b0;
    n_waddr = to_addr(cur_r);
    n_wdata = {key_r, slot_r, h_rdata};
    n_raddr = to_addr(cur_r);

    case (state_r)
      S_CLEAR: begin
        // Sweep all bucket heads to empty.
        h_we    = 1'b1;
        h_waddr = clr_r;
        clr_nxt = clr_r + BW'(1);
        if (32'(clr_r) == HASH_BUCKETS - 1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        // Read the chain head; insert also fetches the free head's next.
        st_nxt    = ST_NOTFOUND;
        hit_nxt   = 1'b0;
        fidx_nxt  = '0;
        prev_nxt  = '0;
        steps_nxt = '0;
        n_raddr   = to_addr(free_r);
        case (cmd_r)
          CMD_LOOKUP, CMD_DELETE: state_nxt = S_HEAD_WAIT;
          CMD_INSERT: begin
            if (link_ok(free_r, POOL_L)) begin
              cur_nxt   = free_r;
              state_nxt = S_FREE_WAIT;
            end else if (alloc_r < POOL_L) begin
              alloc_nxt = alloc_r + LW'(1);
              cur_nxt   = alloc_r + LW'(1);
              state_nxt = S_FREE_WAIT;
            end else begin
              st_nxt    = ST_FULL;
              state_nxt = S_OUT;
            end
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_FREE_WAIT: begin
        // Push the new node at the chain head.
        if (cur_r == free_r) begin
          free_nxt = rd_next;
        end
        n_we    = 1'b1;
        n_wdata = {key_r, slot_r, h_rdata};
        h_we    = 1'b1;
        h_wdata = cur_r;
        st_nxt  = ST_OK;
        state_nxt = S_OUT;
      end
      S_HEAD_WAIT: begin
        cur_nxt   = h_rdata;
        state_nxt = S_NODE_RD;
      end
      S_NODE_RD: begin
        if (link_ok(cur_r, POOL_L) && (steps_r < POOL_L)) begin
          state_nxt = S_NODE_WAIT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_NODE_WAIT: begin
        if (rd_key == key_r) begin
          st_nxt  = ST_OK;
          hit_nxt = 1'b1;
          if (cmd_r == CMD_LOOKUP) begin
            fidx_nxt  = SlotW'(rd_slot);
            state_nxt = S_OUT;
          end else begin
            // Unlink: predecessor or head takes our next.
            if (prev_r == '0) begin
              h_we    = 1'b1;
              h_wdata = rd_next;
            end else begin
              n_we    = 1'b1;
              n_waddr = to_addr(prev_r);
              n_wdata = {pkey_r, pslot_r, rd_next};
            end
            prev_nxt  = rd_next;
            state_nxt = (prev_r == '0) ? S_UNLINK : S_UNLINK;
          end
        end else begin
          prev_nxt  = cur_r;
          pkey_nxt  = rd_key;
          pslot_nxt = rd_slot;
          cur_nxt   = rd_next;
          steps_nxt = steps_r + LW'(1);
          state_nxt = S_NODE_RD;
        end
      end
      S_UNLINK: begin
        // Return the node to the free list; its key stays, its slot is rewritten with the request's slot.
        n_we     = 1'b1;
        n_waddr  = to_addr(cur_r);
        n_wdata  = {key_r, slot_r, free_r};
        free_nxt = cur_r;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- tb/chained_hash_index_table_test.sv -----
`timescale 1ns / 100ps

module chained_hash_index_table_test;
  import chit_pkg::*;

  localparam int unsigned Buckets = HashBucketsDef;
  localparam int unsigned Pool    = NodePoolDef;
  localparam int unsigned Slots   = EntrySlotsDef;

  // One request and one reply, at the widths of the ports.
  typedef struct {
    cmd_t             cmd;
    logic [KeyW-1:0]  block_id;
    logic [SlotW-1:0] entry_index;
  } request_t;

  typedef struct {
    status_t          status;
    logic             hit;
    logic [SlotW-1:0] found_index;
  } reply_t;

  logic clk;
  logic rst_n;

  chit_in_if  in_ch ();
  chit_out_if out_ch ();

  chained_hash_index_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the index: chain heads and the node pool, with links
  // kept as node number plus one so that zero means an empty chain.
  int unsigned      chain_head [Buckets];
  logic [KeyW-1:0]  node_key   [Pool];
  logic [SlotW-1:0] node_slot  [Pool];
  int unsigned      node_next  [Pool];
  int unsigned      nodes_taken;
  int unsigned      free_link;
  int unsigned      live_nodes;

  request_t    pending_requests[$];
  reply_t      expected_replies[$];
  logic [KeyW-1:0] hot_keys[48];

  int          sender_idle_pct;
  int          receiver_idle_pct;
  logic        in_taken;
  int          errors;
  int          n_requests, n_lookup_hits, n_delete_hits, n_pool_full;

  // Apply one request to the shadow index and return the reply it earns.
  function automatic reply_t index_apply(request_t rq);
    reply_t      rp;
    int unsigned bkt, cur, prev, n, steps;
    rp.status = ST_NOTFOUND;
    rp.hit = 1'b0;
    rp.found_index = '0;
    bkt = rq.block_id % Buckets;
    case (rq.cmd)
      CMD_LOOKUP: begin
        cur = chain_head[bkt];
        steps = 0;
        while (cur != 0 && steps < Pool) begin
          if (node_key[cur-1] == rq.block_id) begin
            rp.status = ST_OK;
            rp.hit = 1'b1;
            rp.found_index = node_slot[cur-1];
            n_lookup_hits++;
            break;
          end
          cur = node_next[cur-1];
          steps++;
        end
      end
      CMD_INSERT: begin
        n = 0;
        if (free_link != 0) begin
          n = free_link;
          free_link = node_next[n-1];
        end else if (nodes_taken < Pool) begin
          nodes_taken++;
          n = nodes_taken;
        end
        if (n == 0) begin
          rp.status = ST_FULL;
          n_pool_full++;
        end else begin
          node_key[n-1]  = rq.block_id;
          node_slot[n-1] = rq.entry_index % Slots;
          node_next[n-1] = chain_head[bkt];
          chain_head[bkt] = n;
          live_nodes++;
          rp.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        prev = 0;
        cur = chain_head[bkt];
        steps = 0;
        while (cur != 0 && steps < Pool) begin
          if (node_key[cur-1] == rq.block_id) begin
            // Unlink from the chain, then push onto the free list.
            if (prev == 0) chain_head[bkt] = node_next[cur-1];
            else node_next[prev-1] = node_next[cur-1];
            node_next[cur-1] = free_link;
            free_link = cur;
            live_nodes--;
            rp.status = ST_OK;
            rp.hit = 1'b1;
            n_delete_hits++;
            break;
          end
          prev = cur;
          cur = node_next[cur-1];
          steps++;
        end
      end
      default: ;
    endcase
    return rp;
  endfunction

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 99) < 60) return hot_keys[$urandom_range(0, 47)];
    return $urandom;
  endfunction

  task automatic queue_request(cmd_t c, logic [KeyW-1:0] k, logic [SlotW-1:0] s);
    request_t rq;
    rq.cmd = c;
    rq.block_id = k;
    rq.entry_index = s;
    pending_requests.push_back(rq);
  endtask

  // Mixed traffic; del_pct sets how hard the chains get pruned.
  task automatic queue_mixed(int count, int del_pct);
    int   r;
    cmd_t c;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < del_pct) c = CMD_DELETE;
      else if (r < del_pct + 30) c = CMD_LOOKUP;
      else if (r < del_pct + 33) c = CMD_NONE;
      else c = CMD_INSERT;
      queue_request(c, pick_key(), SlotW'($urandom));
    end
  endtask

  // Hold until the feed is empty and every reply is back, then let the
  // block settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_replies.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOOKUP;
    in_ch.block_id = '0;
    in_ch.entry_index = '0;
    out_ch.ready = 1'b0;
    forever #4 clk = ~clk;
  end

  // Ingress monitor: capture each accepted transfer and predict its reply.
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin : predict_blk
      request_t rq;
      rq.cmd = cmd_t'(in_ch.cmd);
      rq.block_id = in_ch.block_id;
      rq.entry_index = in_ch.entry_index;
      expected_replies.push_back(index_apply(rq));
      n_requests++;
    end
  end

  // Egress monitor: compare each reply transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin : check_blk
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d", out_ch.status);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index,
                 out_ch.found_index);
          errors++;
        end
      end
    end
  end

  // Driver: change inputs on the falling edge, one assignment per signal.
  always @(negedge clk) begin
    if (rst_n) begin : drive_blk
      request_t rq;
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      // Advance only when the slot is empty or its transfer just happened.
      if (!in_ch.valid || in_taken) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          rq = pending_requests.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.cmd          <= rq.cmd;
          in_ch.block_id     <= rq.block_id;
          in_ch.entry_index  <= rq.entry_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Stimulus sequencer.
  initial begin
    errors = 0;
    n_requests = 0;
    n_lookup_hits = 0;
    n_delete_hits = 0;
    n_pool_full = 0;
    nodes_taken = 0;
    free_link = 0;
    live_nodes = 0;
    for (int b = 0; b < Buckets; b++) chain_head[b] = 0;
    // Hot keys crowd a dozen buckets, plus the all-ones key's bucket, so chains grow long and repeat.
    for (int i = 0; i < 48; i++) hot_keys[i] = {24'($urandom), 8'((i % 12) * 21)};
    hot_keys[0] = '0;
    hot_keys[1] = '1;
    sender_idle_pct = 12;
    receiver_idle_pct = 56;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty miss, key extremes, shadowing duplicates, unlink at
    // the head and past it, absent delete, unknown command, node reuse.
    queue_request(CMD_LOOKUP, 32'h0, 12'd5);
    queue_request(CMD_INSERT, 32'h0, 12'd0);
    queue_request(CMD_INSERT, 32'hFFFF_FFFF, 12'hFFF);
    queue_request(CMD_LOOKUP, 32'h0, 12'd0);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 12'd0);
    queue_request(CMD_INSERT, 32'h100, 12'd123);
    queue_request(CMD_INSERT, 32'h0, 12'd77);
    queue_request(CMD_LOOKUP, 32'h0, 12'd0);
    queue_request(CMD_DELETE, 32'h0, 12'hFFF);
    queue_request(CMD_LOOKUP, 32'h0, 12'd0);
    queue_request(CMD_DELETE, 32'h0, 12'd0);
    queue_request(CMD_LOOKUP, 32'h100, 12'd0);
    queue_request(CMD_LOOKUP, 32'h0, 12'd0);
    queue_request(CMD_DELETE, 32'd12345, 12'd0);
    queue_request(CMD_NONE, 32'hFFFF_FFFF, 12'hFFF);
    queue_request(CMD_DELETE, 32'hFFFF_FFFF, 12'd0);
    queue_request(CMD_LOOKUP, 32'hFFFF_FFFF, 12'd0);
    queue_request(CMD_INSERT, 32'hDEAD_BEEF, 12'd2048);
    queue_request(CMD_LOOKUP, 32'hDEAD_BEEF, 12'd0);
    queue_mixed(100, 15);
    wait_drained();

    // Swap the idle rates, fill the pool past full, then prune it with delete-heavy traffic.
    sender_idle_pct = 56;
    receiver_idle_pct = 12;
    for (int i = 0; i < int'(Pool - live_nodes) + 8; i++)
      queue_request(CMD_INSERT, pick_key(), SlotW'($urandom));
    queue_mixed(70, 45);
    wait_drained();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    queue_mixed(70, 20);
    wait_drained();

    $display("covered %0d requests: %0d lookup hits, %0d delete hits, %0d pool-full replies",
             n_requests, n_lookup_hits, n_delete_hits, n_pool_full);
    if (errors == 0) begin
      $display("chained_hash_index_table test passed");
    end else begin
      $display("chained_hash_index_table test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #8ms;
    $display("chained_hash_index_table test failed");
    $finish;
  end

endmodule
